[src/rbi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared widths, codes and types of the ray/box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbi_pkg;

    // coordinate width and fraction bits (Q16.16)
    localparam int CW  = 32;
    localparam int FB  = 16;
    // face tolerance width
    localparam int TW  = 16;
    // divider dividend width: |plane - origin| shifted up by FB
    localparam int NW  = CW + 1 + FB;
    // split of a centre distance magnitude for the squaring step
    localparam int HW  = (CW + 2) / 2;
    localparam int HIW = CW + 1 - HW;
    // squared-distance width
    localparam int DW  = 2 * CW + 4;
    // configuration index width
    localparam int AW  = 3;

    // stream widths
    localparam int IN_W  = ((8 * CW + 7) / 8) * 8;
    localparam int OUT_F = 4 * CW + 3;
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8;

    // saturation limits
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = CW'(1) << FB;

    // configuration register indexes
    localparam logic [AW-1:0] REG_MIN_X = AW'(0);
    localparam logic [AW-1:0] REG_MIN_Y = AW'(1);
    localparam logic [AW-1:0] REG_MIN_Z = AW'(2);
    localparam logic [AW-1:0] REG_MAX_X = AW'(3);
    localparam logic [AW-1:0] REG_MAX_Y = AW'(4);
    localparam logic [AW-1:0] REG_MAX_Z = AW'(5);
    localparam logic [AW-1:0] REG_TOL   = AW'(6);

    // face codes
    localparam logic [2:0] FACE_NONE = 3'd0;
    localparam logic [2:0] FACE_PX   = 3'd1;
    localparam logic [2:0] FACE_PY   = 3'd2;
    localparam logic [2:0] FACE_PZ   = 3'd3;
    localparam logic [2:0] FACE_NX   = 3'd4;
    localparam logic [2:0] FACE_NY   = 3'd5;
    localparam logic [2:0] FACE_NZ   = 3'd6;

    // box configuration
    typedef struct packed {
        logic [2:0][CW-1:0] box_min;
        logic [2:0][CW-1:0] box_max;
        logic [TW-1:0]      tol;
    } t_cfg;

    // per-ray side data riding along the divider
    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] d;
        logic [CW-1:0]      wlo;
        logic [CW-1:0]      whi;
        logic [5:0]         qneg;
        logic [2:0]         zero;
        logic [2:0]         in_slab;
    } t_meta;

endpackage

[src/rbi_div_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_div_lane
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module rbi_div_lane (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [rbi_pkg::NW-1:0]  i_num,
    input  logic [rbi_pkg::CW-1:0]  i_den,
    output logic [rbi_pkg::NW-1:0]  o_quot
);

    localparam int NW = rbi_pkg::NW;
    localparam int CW = rbi_pkg::CW;

    logic [CW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [CW-1:0] r_den [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [CW-1:0] w_rem_in;
        logic [NW-1:0] w_num_in;
        logic [NW-1:0] w_quo_in;
        logic [CW-1:0] w_den_in;
        logic [CW:0]   w_sh;
        logic [CW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
        end

        // shift in next dividend bit, trial subtract
        assign w_sh   = {w_rem_in, w_num_in[NW-1]};
        assign w_diff = w_sh - {1'b0, w_den_in};
        assign w_ge   = (w_sh >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[CW-1:0] : w_sh[CW-1:0];
                r_num[k] <= {w_num_in[NW-2:0], 1'b0};
                r_quo[k] <= {w_quo_in[NW-2:0], w_ge};
                r_den[k] <= w_den_in;
            end
        end
    end

    assign o_quot = r_quo[NW-1];

endmodule

[src/rbi_face_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_face_unit
// Hit point along the ray, face test and nearest-centre face selection.
// ----------------------------------------------------------------------------
module rbi_face_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  rbi_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    input  logic                         i_hit,
    input  logic [rbi_pkg::CW-1:0]       i_t,
    input  logic [2:0][rbi_pkg::CW-1:0]  i_o,
    input  logic [2:0][rbi_pkg::CW-1:0]  i_d,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [rbi_pkg::CW-1:0]       o_t,
    output logic [2:0][rbi_pkg::CW-1:0]  o_p,
    output logic [2:0]                   o_face
);

    localparam int CW  = rbi_pkg::CW;
    localparam int FB  = rbi_pkg::FB;
    localparam int TW  = rbi_pkg::TW;
    localparam int HW  = rbi_pkg::HW;
    localparam int HIW = rbi_pkg::HIW;
    localparam int DW  = rbi_pkg::DW;

    localparam logic [2:0] FACE_OF [6] = '{rbi_pkg::FACE_PX, rbi_pkg::FACE_PY,
        rbi_pkg::FACE_PZ, rbi_pkg::FACE_NX, rbi_pkg::FACE_NY, rbi_pkg::FACE_NZ};

    typedef struct packed {
        logic               hit;
        logic [CW-1:0]      t;
        logic [2:0][CW-1:0] p;
    } t_hit_info;

    typedef struct packed {
        logic          on;
        logic [DW-1:0] sq_dist;
        logic [2:0]    code;
    } t_cand;

    // later face wins only when strictly nearer, or when the earlier is not on its face
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.on && (!a.on || (b.sq_dist < a.sq_dist))) begin
            return b;
        end
        return a;
    endfunction

    logic [9:1] r_v;

    // stage 1: direction times entry distance
    logic signed [2*CW-1:0] w_prod  [3];
    logic signed [2*CW-1:0] r1_prod [3];
    t_hit_info              r1_info;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_prod[a] = $signed(i_d[a]) * $signed(i_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= w_prod;
            r1_info <= '{hit: i_hit, t: i_t, p: i_o};
        end
    end

    // stage 2: floor shift, add origin, saturate
    logic signed [2*CW:0] w_sum [3];
    logic [CW+1:0]        w_top [3];
    logic [2:0][CW-1:0]   w_pt;
    t_hit_info            r2_info;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sum[a] = ($signed({r1_prod[a][2*CW-1], r1_prod[a]}) >>> FB)
                     + $signed({{(CW+1){r1_info.p[a][CW-1]}}, r1_info.p[a]});
            w_top[a] = w_sum[a][2*CW:CW-1];
            if ((&w_top[a]) || !(|w_top[a])) begin
                w_pt[a] = w_sum[a][CW-1:0];
            end else begin
                w_pt[a] = w_sum[a][2*CW] ? rbi_pkg::CMIN : rbi_pkg::CMAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_info <= '{hit: r1_info.hit, t: r1_info.t, p: w_pt};
        end
    end

    // stage 3: distances to planes and to the centre
    logic [CW:0]   w_cen_sum [3];
    logic [CW:0]   w_cen     [3];
    logic [CW+1:0] w_dc      [3];
    logic [CW+1:0] w_dcm     [3];
    logic [CW:0]   w_dmax    [3];
    logic [CW:0]   w_dmin    [3];
    logic [CW:0]   w_amax    [3];
    logic [CW:0]   w_amin    [3];
    logic [CW:0]   w_tol;
    logic [CW:0]   r3_ac [3];
    logic [TW-1:0] r3_pm [6];
    logic [5:0]    r3_on;

    assign w_tol = {{(CW+1-TW){1'b0}}, i_cfg.tol};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cen_sum[a] = {i_cfg.box_min[a][CW-1], i_cfg.box_min[a]}
                         + {i_cfg.box_max[a][CW-1], i_cfg.box_max[a]};
            w_cen[a]  = {w_cen_sum[a][CW], w_cen_sum[a][CW:1]};
            w_dc[a]   = {r2_info.p[a][CW-1], r2_info.p[a][CW-1], r2_info.p[a]}
                      - {w_cen[a][CW], w_cen[a]};
            w_dcm[a]  = w_dc[a][CW+1] ? (~w_dc[a] + 1'b1) : w_dc[a];
            w_dmax[a] = {r2_info.p[a][CW-1], r2_info.p[a]}
                      - {i_cfg.box_max[a][CW-1], i_cfg.box_max[a]};
            w_dmin[a] = {r2_info.p[a][CW-1], r2_info.p[a]}
                      - {i_cfg.box_min[a][CW-1], i_cfg.box_min[a]};
            w_amax[a] = w_dmax[a][CW] ? (~w_dmax[a] + 1'b1) : w_dmax[a];
            w_amin[a] = w_dmin[a][CW] ? (~w_dmin[a] + 1'b1) : w_dmin[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r3_ac[a]   <= w_dcm[a][CW:0];
                r3_pm[a]   <= w_amax[a][TW-1:0];
                r3_pm[a+3] <= w_amin[a][TW-1:0];
                r3_on[a]   <= (w_amax[a] <= w_tol);
                r3_on[a+3] <= (w_amin[a] <= w_tol);
            end
        end
    end

    // stage 4: partial products of the squares
    logic [2*HIW-1:0]  r4_hh  [3];
    logic [HIW+HW-1:0] r4_hl  [3];
    logic [2*HW-1:0]   r4_ll  [3];
    logic [2*TW-1:0]   r4_psq [6];
    logic [5:0]        r4_on;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r4_hh[a] <= (2*HIW)'(r3_ac[a][CW:HW]) * (2*HIW)'(r3_ac[a][CW:HW]);
                r4_hl[a] <= (HIW+HW)'(r3_ac[a][CW:HW]) * (HIW+HW)'(r3_ac[a][HW-1:0]);
                r4_ll[a] <= (2*HW)'(r3_ac[a][HW-1:0]) * (2*HW)'(r3_ac[a][HW-1:0]);
            end
            for (int k = 0; k < 6; k++) begin
                r4_psq[k] <= (2*TW)'(r3_pm[k]) * (2*TW)'(r3_pm[k]);
            end
            r4_on <= r3_on;
        end
    end

    // stage 5: assemble centre-distance squares
    logic [DW-1:0]   r5_sqc [3];
    logic [2*TW-1:0] r5_psq [6];
    logic [5:0]      r5_on;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r5_sqc[a] <= (DW'(r4_hh[a]) << (2*HW)) + (DW'(r4_hl[a]) << (HW+1))
                           + DW'(r4_ll[a]);
            end
            r5_psq <= r4_psq;
            r5_on  <= r4_on;
        end
    end

    // stage 6: squared distance to each face centre
    t_cand w_cand  [6];
    t_cand r6_cand [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_cand[k].on      = r5_on[k];
            w_cand[k].code    = FACE_OF[k];
            w_cand[k].sq_dist = '0;
            for (int b = 0; b < 3; b++) begin
                w_cand[k].sq_dist = w_cand[k].sq_dist
                                  + ((b == (k % 3)) ? DW'(r5_psq[k]) : r5_sqc[b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_cand <= w_cand;
        end
    end

    // stages 7 to 9: selection tree, order kept left to right
    t_cand r7_cand [3];
    t_cand r8_a;
    t_cand r8_b;
    t_cand w_best;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_cand[0] <= pick(r6_cand[0], r6_cand[1]);
            r7_cand[1] <= pick(r6_cand[2], r6_cand[3]);
            r7_cand[2] <= pick(r6_cand[4], r6_cand[5]);
            r8_a       <= pick(r7_cand[0], r7_cand[1]);
            r8_b       <= r7_cand[2];
        end
    end

    assign w_best = pick(r8_a, r8_b);

    // hit data delay line alongside stages 3 to 8
    t_hit_info r_dly [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r2_info;
            for (int k = 1; k < 6; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // output register, a miss gives all zeros
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit  <= r_dly[5].hit;
            o_t    <= r_dly[5].hit ? r_dly[5].t : '0;
            o_p    <= r_dly[5].hit ? r_dly[5].p : '0;
            o_face <= (r_dly[5].hit && w_best.on) ? w_best.code : rbi_pkg::FACE_NONE;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[8:1], i_valid};
        end
    end

    assign o_valid = r_v[9];

endmodule

[src/ray_box_intersection_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_intersection_top
// Ray against axis-aligned box, slab method, Q16.16, one ray per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one ray per transaction, tdata holds origin_x/y/z,
//   dir_x/y/z, window_low, window_high (32 bits each, lowest first).
//   Master stream: one result per ray, tuser[0] = is_hit, tdata holds
//   hit_t, point_x/y/z (32 bits each) and face_code (3 bits), zero padded.
//   Config port: write enable, register index, 32-bit data; write only
//   while no ray is in flight, the box is read at several stages.
//   Throughput: one ray per cycle while the master side does not stall.
//   Division: pipelined restoring dividers, one quotient bit per stage,
//   six lanes in parallel.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default box [-1, 1]^3 with tolerance 2.
//   A stall on the master side freezes the whole pipeline; tready on the
//   slave side is low only while a result waits and is not taken.
// ----------------------------------------------------------------------------
module ray_box_intersection_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, window_low, window_high
    input  logic [rbi_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // hit_t, point_x, point_y, point_z, face_code, zero pad
    output logic [rbi_pkg::OUT_W-1:0]  o_m_axis_tdata,
    // is_hit
    output logic [0:0]                 o_m_axis_tuser,
    input  logic                       i_cfg_we,
    input  logic [rbi_pkg::AW-1:0]     i_cfg_addr,
    input  logic [rbi_pkg::CW-1:0]     i_cfg_wdata
);

    localparam int CW = rbi_pkg::CW;
    localparam int FB = rbi_pkg::FB;
    localparam int NW = rbi_pkg::NW;
    localparam int TW = rbi_pkg::TW;

    function automatic logic [CW-1:0] sat_quot(input logic [NW-1:0] q, input logic neg);
        if (!neg) begin
            return (q > NW'(rbi_pkg::CMAX)) ? rbi_pkg::CMAX : q[CW-1:0];
        end
        return (q > NW'(rbi_pkg::CMIN)) ? rbi_pkg::CMIN : (~q[CW-1:0] + 1'b1);
    endfunction

    rbi_pkg::t_cfg r_cfg;
    logic          w_en;
    logic          w_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_min <= {3{-rbi_pkg::ONE}};
            r_cfg.box_max <= {3{rbi_pkg::ONE}};
            r_cfg.tol     <= TW'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rbi_pkg::REG_MIN_X: r_cfg.box_min[0] <= i_cfg_wdata;
                rbi_pkg::REG_MIN_Y: r_cfg.box_min[1] <= i_cfg_wdata;
                rbi_pkg::REG_MIN_Z: r_cfg.box_min[2] <= i_cfg_wdata;
                rbi_pkg::REG_MAX_X: r_cfg.box_max[0] <= i_cfg_wdata;
                rbi_pkg::REG_MAX_Y: r_cfg.box_max[1] <= i_cfg_wdata;
                rbi_pkg::REG_MAX_Z: r_cfg.box_max[2] <= i_cfg_wdata;
                rbi_pkg::REG_TOL:   r_cfg.tol        <= i_cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result waits
    assign w_en            = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1: dividend and divisor magnitudes, zero-direction test
    logic [CW-1:0]   w_o     [3];
    logic [CW-1:0]   w_d     [3];
    logic [CW-1:0]   w_pl    [6];
    logic [CW:0]     w_numd  [6];
    logic [CW:0]     w_mag   [6];
    logic [NW-1:0]   w_dvd   [6];
    logic [CW-1:0]   w_den   [3];
    logic signed [CW-1:0] w_lo [3];
    logic signed [CW-1:0] w_hi [3];
    rbi_pkg::t_meta  w_meta;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_o[a] = i_s_axis_tdata[a*CW +: CW];
            w_d[a] = i_s_axis_tdata[(a+3)*CW +: CW];
            w_pl[2*a]   = r_cfg.box_min[a];
            w_pl[2*a+1] = r_cfg.box_max[a];
            w_den[a] = w_d[a][CW-1] ? (~w_d[a] + 1'b1) : w_d[a];
            if ($signed(r_cfg.box_min[a]) < $signed(r_cfg.box_max[a])) begin
                w_lo[a] = $signed(r_cfg.box_min[a]);
                w_hi[a] = $signed(r_cfg.box_max[a]);
            end else begin
                w_lo[a] = $signed(r_cfg.box_max[a]);
                w_hi[a] = $signed(r_cfg.box_min[a]);
            end
            w_meta.o[a]       = w_o[a];
            w_meta.d[a]       = w_d[a];
            w_meta.zero[a]    = (w_d[a] == '0);
            w_meta.in_slab[a] = ($signed(w_o[a]) >= w_lo[a]) && ($signed(w_o[a]) <= w_hi[a]);
        end
        for (int j = 0; j < 6; j++) begin
            w_numd[j] = {w_pl[j][CW-1], w_pl[j]} - {w_o[j/2][CW-1], w_o[j/2]};
            w_mag[j]  = w_numd[j][CW] ? (~w_numd[j] + 1'b1) : w_numd[j];
            w_dvd[j]  = {w_mag[j], {FB{1'b0}}};
            w_meta.qneg[j] = w_numd[j][CW] ^ w_d[j/2][CW-1];
        end
        w_meta.wlo = i_s_axis_tdata[6*CW +: CW];
        w_meta.whi = i_s_axis_tdata[7*CW +: CW];
    end

    logic            r1_valid;
    logic [NW-1:0]   r1_dvd [6];
    logic [CW-1:0]   r1_den [3];
    rbi_pkg::t_meta  r1_meta;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dvd  <= w_dvd;
            r1_den  <= w_den;
            r1_meta <= w_meta;
        end
    end

    // six divider lanes, min and max plane per axis
    logic [NW-1:0] w_quot [6];

    for (genvar j = 0; j < 6; j++) begin : g_lane
        rbi_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r1_dvd[j]),
            .i_den  (r1_den[j/2]),
            .o_quot (w_quot[j])
        );
    end

    // side data and valid bits alongside the dividers
    rbi_pkg::t_meta r_meta [NW];
    logic [NW-1:0]  r_mv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta[0] <= r1_meta;
            for (int k = 1; k < NW; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // stage 2: saturate, order, unbounded slabs
    logic signed [CW-1:0] w_q [6];
    logic signed [CW-1:0] r2_t0 [3];
    logic signed [CW-1:0] r2_t1 [3];
    logic [2:0]           r2_miss;
    rbi_pkg::t_meta       r2_meta;
    logic                 r2_valid;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_q[j] = $signed(sat_quot(w_quot[j], r_meta[NW-1].qneg[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_meta[NW-1].zero[a]) begin
                    r2_t0[a] <= $signed(rbi_pkg::CMIN);
                    r2_t1[a] <= $signed(rbi_pkg::CMAX);
                end else if (w_q[2*a] > w_q[2*a+1]) begin
                    r2_t0[a] <= w_q[2*a+1];
                    r2_t1[a] <= w_q[2*a];
                end else begin
                    r2_t0[a] <= w_q[2*a];
                    r2_t1[a] <= w_q[2*a+1];
                end
                r2_miss[a] <= r_meta[NW-1].zero[a] && !r_meta[NW-1].in_slab[a];
            end
            r2_meta <= r_meta[NW-1];
        end
    end

    // stage 3: narrow by the y slab
    logic signed [CW-1:0] r3_tmin;
    logic signed [CW-1:0] r3_tmax;
    logic signed [CW-1:0] r3_z0;
    logic signed [CW-1:0] r3_z1;
    logic                 r3_miss;
    rbi_pkg::t_meta       r3_meta;
    logic                 r3_valid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_tmin <= (r2_t0[1] > r2_t0[0]) ? r2_t0[1] : r2_t0[0];
            r3_tmax <= (r2_t1[1] < r2_t1[0]) ? r2_t1[1] : r2_t1[0];
            r3_miss <= r2_miss[0] || r2_miss[1]
                    || (r2_t0[0] > r2_t1[1]) || (r2_t0[1] > r2_t1[0]);
            r3_z0   <= r2_t0[2];
            r3_z1   <= r2_t1[2];
            r3_meta <= r2_meta;
        end
    end

    // z-slab miss delayed to stage 3
    logic r2_miss_z_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_miss_z_d <= r2_miss[2];
        end
    end

    // stage 4: narrow by the z slab, window check
    logic signed [CW-1:0] w_wlo;
    logic signed [CW-1:0] w_whi;
    logic                 r4_hit;
    logic [CW-1:0]        r4_tmin;
    rbi_pkg::t_meta       r4_meta;
    logic                 r4_valid;

    assign w_wlo = $signed(r3_meta.wlo);
    assign w_whi = $signed(r3_meta.whi);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_tmin <= (r3_z0 > r3_tmin) ? r3_z0 : r3_tmin;
            r4_hit  <= !r3_miss && !r2_miss_z_d
                    && !((r3_tmin > r3_z1) || (r3_z0 > r3_tmax))
                    && ((r3_tmin > w_wlo) || (r3_z0 > w_wlo))
                    && ((r3_tmax < w_whi) || (r3_z1 < w_whi));
            r4_meta <= r3_meta;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_mv     <= '0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_s_axis_tvalid;
            r_mv     <= {r_mv[NW-2:0], r1_valid};
            r2_valid <= r_mv[NW-1];
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // hit point and face
    logic                 w_hit;
    logic [CW-1:0]        w_t;
    logic [2:0][CW-1:0]   w_p;
    logic [2:0]           w_face;

    rbi_face_unit u_face (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (r4_valid),
        .i_hit   (r4_hit),
        .i_t     (r4_tmin),
        .i_o     (r4_meta.o),
        .i_d     (r4_meta.d),
        .o_valid (w_out_valid),
        .o_hit   (w_hit),
        .o_t     (w_t),
        .o_p     (w_p),
        .o_face  (w_face)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tuser  = w_hit;
    assign o_m_axis_tdata  = {{(rbi_pkg::OUT_W-rbi_pkg::OUT_F){1'b0}},
                              w_face, w_p[2], w_p[1], w_p[0], w_t};

endmodule

[src/rbi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks of the ray/box intersection block, bound to the top.
// ----------------------------------------------------------------------------
module rbi_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [rbi_pkg::OUT_W-1:0]  o_m_axis_tdata,
    input logic [0:0]                 o_m_axis_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> (o_m_axis_tdata == '0))
        else $error("miss with nonzero payload");

    // input side is open whenever no result is pending
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind ray_box_intersection_top rbi_checker u_rbi_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_box_intersection_top: rays are streamed in under
// random valid/ready gaps, each accepted ray is run through a local slab-test
// model and the returned hit, distance, point and face are compared in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int  RUN_LIMIT = 400000;
    localparam int  DRAIN     = 80;

    typedef struct {
        bit        hit;
        bit [31:0] t;
        bit [31:0] px;
        bit [31:0] py;
        bit [31:0] pz;
        bit [2:0]  face;
    } t_hit;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [rbi_pkg::IN_W-1:0]    s_data = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [rbi_pkg::OUT_W-1:0]   m_data;
    logic [0:0]                  m_user;
    logic                        cfg_we = 1'b0;
    logic [rbi_pkg::AW-1:0]      cfg_addr = '0;
    logic [rbi_pkg::CW-1:0]      cfg_wdata = '0;

    // local copy of the box registers
    longint             box_lo [3];
    longint             box_hi [3];
    longint             face_tol;

    logic [rbi_pkg::IN_W-1:0] ray_queue [$];
    t_hit               hit_queue [$];
    int                 errors = 0;
    int                 cyc = 0;
    int                 hold_cnt = 0;
    bit                 hold_done = 1'b0;
    bit                 fired = 1'b0;

    ray_box_intersection_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint field(logic [rbi_pkg::IN_W-1:0] r, int i);
        return longint'($signed(r[32*i +: 32]));
    endfunction

    // entry/exit of one slab, 0 when the ray misses it
    function automatic bit slab_span(longint lo, longint hi, longint o, longint d,
                                     output longint t0, output longint t1);
        longint a;
        longint b;
        longint l;
        longint h;
        l = (lo < hi) ? lo : hi;
        h = (lo < hi) ? hi : lo;
        if (d == 0) begin
            t0 = -64'sd2147483648;
            t1 = 64'sd2147483647;
            return (o >= l && o <= h);
        end
        a = sat32(((lo - o) * 65536) / d);
        b = sat32(((hi - o) * 65536) / d);
        t0 = (a > b) ? b : a;
        t1 = (a > b) ? a : b;
        return 1'b1;
    endfunction

    function automatic t_hit predict_hit(logic [rbi_pkg::IN_W-1:0] r);
        t_hit    res;
        longint  o [3];
        longint  d [3];
        longint  p [3];
        longint  c [3];
        longint  f [3];
        longint  tmin;
        longint  tmax;
        longint  a;
        longint  b;
        longint  plane;
        longint  diff;
        bit [79:0] sq_sum;
        bit [79:0] best;
        bit [79:0] m;
        int      ax;
        res = '{0, 0, 0, 0, 0, rbi_pkg::FACE_NONE};
        for (int i = 0; i < 3; i++) begin
            o[i] = field(r, i);
            d[i] = field(r, i + 3);
        end
        tmin = 0;
        tmax = 0;
        for (int i = 0; i < 3; i++) begin
            if (!slab_span(box_lo[i], box_hi[i], o[i], d[i], a, b)) return res;
            if (i == 0) begin
                tmin = a;
                tmax = b;
            end else begin
                if (tmin > b || a > tmax) return res;
                if (a > tmin) tmin = a;
                if (b < tmax) tmax = b;
            end
        end
        if (!(tmin > field(r, 6) && tmax < field(r, 7))) return res;
        for (int i = 0; i < 3; i++) begin
            p[i] = sat32(o[i] + ((d[i] * tmin) >>> 16));
            c[i] = (box_lo[i] + box_hi[i]) >>> 1;
        end
        best = '0;
        // faces in priority order +x,+y,+z,-x,-y,-z
        for (int k = 0; k < 6; k++) begin
            ax = k % 3;
            plane = (k < 3) ? box_hi[ax] : box_lo[ax];
            diff = p[ax] - plane;
            if (diff < 0) diff = -diff;
            if (diff <= face_tol) begin
                f = c;
                f[ax] = plane;
                sq_sum = '0;
                for (int i = 0; i < 3; i++) begin
                    diff = p[i] - f[i];
                    if (diff < 0) diff = -diff;
                    m = 80'(diff);
                    sq_sum = sq_sum + m * m;
                end
                if (res.face == rbi_pkg::FACE_NONE || sq_sum < best) begin
                    best = sq_sum;
                    res.face = 3'(k + 1);
                end
            end
        end
        res.hit = 1'b1;
        res.t   = tmin[31:0];
        res.px  = p[0][31:0];
        res.py  = p[1][31:0];
        res.pz  = p[2][31:0];
        return res;
    endfunction

    // cycle count, timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // sender: hold an offered ray until it is taken
    always @(negedge i_clk) begin
        if (s_valid && !fired) begin
            s_valid <= 1'b1;
        end else if (ray_queue.size() > 0 &&
                     ((cyc > 500 && cyc < 1300) || $urandom_range(99) >= 26)) begin
            s_valid <= 1'b1;
            s_data  <= ray_queue[0];
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: random stalls, one long hold-off while rays keep coming
    always @(negedge i_clk) begin
        if (!hold_done && cyc > 1500 && ray_queue.size() > 150) begin
            hold_done <= 1'b1;
            hold_cnt  <= 300;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= (cyc > 500 && cyc < 1300) || ($urandom_range(99) >= 26);
        end
    end

    // predict on accepted rays
    always @(posedge i_clk) begin
        fired <= s_valid && s_ready && i_rst_n;
        if (i_rst_n && s_valid && s_ready) begin
            hit_queue.push_back(predict_hit(s_data));
            void'(ray_queue.pop_front());
        end
    end

    task automatic check_field(string name, bit [31:0] want, bit [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // compare results in order
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && m_valid && m_ready) begin
            if (hit_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h/%h",
                         $time, m_user, m_data);
            end else begin
                want = hit_queue.pop_front();
                check_field("is_hit", 32'(want.hit), 32'(m_user[0]));
                check_field("hit_t", want.t, m_data[31:0]);
                check_field("point_x", want.px, m_data[63:32]);
                check_field("point_y", want.py, m_data[95:64]);
                check_field("point_z", want.pz, m_data[127:96]);
                check_field("face_code", 32'(want.face), 32'(m_data[130:128]));
                check_field("pad", 32'd0, 32'(m_data[rbi_pkg::OUT_W-1:131]));
            end
        end
    end

    task automatic write_reg(logic [rbi_pkg::AW-1:0] idx, longint v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v[31:0];
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == rbi_pkg::REG_TOL) face_tol = v & 16'hFFFF;
        else if (idx < rbi_pkg::REG_MAX_X) box_lo[idx] = longint'($signed(v[31:0]));
        else box_hi[idx - rbi_pkg::REG_MAX_X] = longint'($signed(v[31:0]));
    endtask

    task automatic set_box(longint lx, longint ly, longint lz,
                           longint hx, longint hy, longint hz, longint tol);
        write_reg(rbi_pkg::REG_MIN_X, lx);
        write_reg(rbi_pkg::REG_MIN_Y, ly);
        write_reg(rbi_pkg::REG_MIN_Z, lz);
        write_reg(rbi_pkg::REG_MAX_X, hx);
        write_reg(rbi_pkg::REG_MAX_Y, hy);
        write_reg(rbi_pkg::REG_MAX_Z, hz);
        write_reg(rbi_pkg::REG_TOL, tol);
    endtask

    task automatic push_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                            longint dz, longint wlo, longint whi);
        logic [rbi_pkg::IN_W-1:0] r;
        r = {whi[31:0], wlo[31:0], dz[31:0], dy[31:0], dx[31:0],
             oz[31:0], oy[31:0], ox[31:0]};
        ray_queue.push_back(r);
    endtask

    task automatic wait_idle();
        while (ray_queue.size() > 0 || hit_queue.size() > 0 || s_valid) @(negedge i_clk);
    endtask

    // random rays: mostly aimed at the box, some noise
    task automatic random_rays(int count);
        longint tg [3];
        longint o [3];
        longint d [3];
        longint lo;
        longint hi;
        int     kind;
        int     sh;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            end else if (kind < 25) begin
                push_ray($signed($urandom) >>> 12, $signed($urandom) >>> 12,
                         $signed($urandom) >>> 12, $signed($urandom) >>> 12,
                         $signed($urandom) >>> 12, $signed($urandom) >>> 12,
                         $signed($urandom) >>> 14, $signed($urandom) >>> 8);
            end else begin
                sh = $urandom_range(20, 0);
                for (int i = 0; i < 3; i++) begin
                    lo = (box_lo[i] < box_hi[i]) ? box_lo[i] : box_hi[i];
                    hi = (box_lo[i] < box_hi[i]) ? box_hi[i] : box_lo[i];
                    case ($urandom_range(5))
                        0: tg[i] = lo;
                        1: tg[i] = hi;
                        default: tg[i] = lo + longint'($urandom_range(32'(hi - lo)));
                    endcase
                    o[i] = sat32(tg[i] + (longint'($signed($urandom)) >>> sh));
                    d[i] = sat32(tg[i] - o[i]) >>> $urandom_range(3);
                    if ($urandom_range(9) == 0) d[i] = 0;
                end
                push_ray(o[0], o[1], o[2], d[0], d[1], d[2],
                         ($urandom_range(3) == 0) ? longint'($signed($urandom))
                                                  : -longint'($urandom_range(1 << 20)),
                         ($urandom_range(3) == 0) ? longint'($signed($urandom))
                                                  : 64'sd2147483647);
            end
        end
    endtask

    initial begin
        box_lo = '{-65536, -65536, -65536};
        box_hi = '{65536, 65536, 65536};
        face_tol = 2;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rays on the reset box
        push_ray(131072, 0, 0, -65536, 0, 0, -1, 64'sd2147483647);        // +x face
        push_ray(-131072, 0, 0, 65536, 0, 0, -1, 64'sd2147483647);        // -x face
        push_ray(0, 131072, 0, 0, -65536, 0, -1, 64'sd2147483647);        // +y face
        push_ray(0, -131072, 0, 0, 65536, 0, -1, 64'sd2147483647);        // -y face
        push_ray(0, 0, 131072, 0, 0, -65536, -1, 64'sd2147483647);        // +z face
        push_ray(0, 0, -131072, 0, 0, 65536, -1, 64'sd2147483647);        // -z face
        push_ray(131072, 131072, 131072, -65536, -65536, -65536,
                 -1, 64'sd2147483647);                                    // corner tie
        push_ray(131072, 131072, 0, -65536, -65536, 0,
                 -1, 64'sd2147483647);                                    // edge tie
        push_ray(0, 0, 0, 65536, 0, 0, -64'sd2147483648, 64'sd2147483647); // inside box
        push_ray(0, 131072, 0, 65536, 0, 0, -1, 64'sd2147483647);         // parallel miss
        push_ray(131072, 0, 0, -65536, 0, 0, 131072, 64'sd2147483647);    // window low
        push_ray(131072, 0, 0, -65536, 0, 0, -1, 131072);                 // window high
        push_ray(0, 0, 0, 0, 0, 0, -64'sd2147483648, 64'sd2147483647);    // zero dir
        push_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                 -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                 -64'sd2147483648, 64'sd2147483647);
        push_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                 -64'sd2147483648, 64'sd2147483647);
        push_ray(65536, 0, 0, 1, 1, 1, -64'sd2147483648, 64'sd2147483647);
        random_rays(300);
        wait_idle();

        // full-range box, widest tolerance
        set_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 65535);
        random_rays(300);
        wait_idle();

        // swapped corners, zero tolerance
        set_box(327680, 200000, -50000, -131072, -400000, -700000, 0);
        random_rays(300);
        wait_idle();

        // tiny box with a tolerance larger than it
        set_box(10, -3, 0, 12, 3, 1, 65535);
        random_rays(300);
        wait_idle();

        // random boxes
        for (int ph = 0; ph < 3; ph++) begin
            set_box($signed($urandom) >>> 4, $signed($urandom) >>> 4,
                    $signed($urandom) >>> 4, $signed($urandom) >>> 4,
                    $signed($urandom) >>> 4, $signed($urandom) >>> 4,
                    $urandom_range(300));
            random_rays(200);
            wait_idle();
        end

        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
